>>> src/khc_pkg.sv
// shared types and constants for the keyed handle cache
`default_nettype none

package khc_pkg;

  localparam int DEFAULT_ENTRIES     = 32;
  localparam int DEFAULT_COUNT_WIDTH = 16;

  localparam int OPC_W       = 2;
  localparam int KEY_W       = 64;
  localparam int SLOT_W      = 5;
  localparam int COUNT_OUT_W = 16;

  typedef enum logic [OPC_W-1:0] {
    OP_LOOKUP  = 2'd0,
    OP_INSERT  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef struct packed {
    logic                   found;
    logic [SLOT_W-1:0]      slot_out;
    logic                   table_full;
    logic                   underflow;
    logic [COUNT_OUT_W-1:0] count_out;
  } res_t;

  localparam res_t RES_NONE = '0;

endpackage

`default_nettype wire

>>> src/khc_if.sv
// request and response channel interfaces of the keyed handle cache
`default_nettype none

interface khc_req_if;
  logic                            valid;
  logic                            ready;
  logic [khc_pkg::OPC_W-1:0]       opcode;
  logic [khc_pkg::KEY_W-1:0]       key_high;
  logic [khc_pkg::KEY_W-1:0]       key_low;
  logic [khc_pkg::SLOT_W-1:0]      slot_in;

  modport source(output valid, output opcode, output key_high, output key_low,
                 output slot_in, input ready);
  modport sink(input valid, input opcode, input key_high, input key_low,
               input slot_in, output ready);
endinterface

interface khc_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [khc_pkg::SLOT_W-1:0]      slot_out;
  logic                            table_full;
  logic                            underflow;
  logic [khc_pkg::COUNT_OUT_W-1:0] count_out;

  modport source(output valid, output found, output slot_out, output table_full,
                 output underflow, output count_out, input ready);
  modport sink(input valid, input found, input slot_out, input table_full,
               input underflow, input count_out, output ready);
endinterface

`default_nettype wire

>>> src/khc_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module khc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/keyed_handle_cache_refcount.sv
// top level: reference-counted key table with a sequential scan engine
// lookup compares one key per cycle against the registered ram read, insert checks one valid
// bit per cycle, release reads the count ram and then writes it back, clear drops every valid bit;
// each result waits in S_EMIT until the output register takes it
// one request in flight at a time; a new beat is taken while the last result still waits
// reset clears the valid bits and control state, not the rams; ram data counts only for valid entries
`default_nettype none

module keyed_handle_cache_refcount #(
  parameter int ENTRIES     = khc_pkg::DEFAULT_ENTRIES,
  parameter int COUNT_WIDTH = khc_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  khc_req_if.sink       req,
  khc_rsp_if.source     rsp
);

  import khc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int KW2   = 2 * KEY_W;
  localparam logic [IDX_W-1:0]       LAST    = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W-1:0]       IDX_ONE = IDX_W'(1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOOK   = 6'b000010,
    S_INS    = 6'b000100,
    S_REL_RD = 6'b001000,
    S_REL    = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state;

  // request registers
  logic [KW2-1:0]    key_req;
  logic [SLOT_W-1:0] rel_slot;

  // scan engine: scan issues ram reads, cmp_idx names the entry whose data is back
  logic [IDX_W-1:0]  scan;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_live;
  logic              issue_done;

  logic [ENTRIES-1:0] valid;

  // result waiting for the output register, and the output register itself
  res_t res;
  res_t out_res;
  logic out_valid;
  logic out_load;

  // ram ports
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [KW2-1:0]         key_rd;
  logic [COUNT_WIDTH-1:0] cnt_rd;
  logic                   key_wr_en;
  logic                   cnt_wr_en;
  logic [IDX_W-1:0]       cnt_wr_addr;
  logic [COUNT_WIDTH-1:0] cnt_wr_data;

  // width adaption between fixed port fields and parameter-sized indexes
  logic [IDX_W+SLOT_W-1:0]            rel_wide;
  logic [IDX_W-1:0]                   rel_idx;
  logic [SLOT_W+IDX_W-1:0]            cmp_slot_wide;
  logic [SLOT_W+IDX_W-1:0]            scan_slot_wide;
  logic [COUNT_OUT_W+COUNT_WIDTH-1:0] inc_wide;
  logic [COUNT_OUT_W+COUNT_WIDTH-1:0] dec_wide;

  logic                   accept;
  logic                   in_range;
  logic                   key_hit;
  logic                   look_hit;
  logic                   ins_free;
  logic                   rel_ok;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_dec;

  // packs one result beat
  function automatic res_t make_res(logic fnd, logic [SLOT_W-1:0] slot, logic full,
                                    logic under, logic [COUNT_OUT_W-1:0] cnt);
    res_t r;
    r.found      = fnd;
    r.slot_out   = slot;
    r.table_full = full;
    r.underflow  = under;
    r.count_out  = cnt;
    return r;
  endfunction

  assign accept   = req.valid & req.ready;
  assign req.ready = (state == S_IDLE);
  assign in_range = {{(32-SLOT_W){1'b0}}, req.slot_in} < 32'(ENTRIES);

  assign rel_wide       = {{IDX_W{1'b0}}, rel_slot};
  assign rel_idx        = rel_wide[IDX_W-1:0];
  assign cmp_slot_wide  = {{SLOT_W{1'b0}}, cmp_idx};
  assign scan_slot_wide = {{SLOT_W{1'b0}}, scan};

  // the key compare unit: one 128-bit key equality per cycle
  assign key_hit  = (key_rd == key_req);
  assign look_hit = (state == S_LOOK) && cmp_live && valid[cmp_idx] && key_hit;
  assign ins_free = (state == S_INS) && !valid[scan];
  assign rel_ok   = (state == S_REL) && valid[rel_idx] && (cnt_rd != '0);

  // saturating acquire and plain release
  assign cnt_inc  = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + CNT_ONE;
  assign cnt_dec  = cnt_rd - CNT_ONE;
  assign inc_wide = {{COUNT_OUT_W{1'b0}}, cnt_inc};
  assign dec_wide = {{COUNT_OUT_W{1'b0}}, cnt_dec};

  // ram control
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = scan;
    cnt_wr_en   = 1'b0;
    cnt_wr_addr = scan;
    cnt_wr_data = CNT_ONE;
    key_wr_en   = ins_free;
    if ((state == S_LOOK) && !issue_done) begin
      rd_en = 1'b1;
    end else if (state == S_REL_RD) begin
      rd_en   = 1'b1;
      rd_addr = rel_idx;
    end
    if (ins_free) begin
      cnt_wr_en = 1'b1;
    end else if (look_hit) begin
      cnt_wr_en   = 1'b1;
      cnt_wr_addr = cmp_idx;
      cnt_wr_data = cnt_inc;
    end else if (rel_ok) begin
      cnt_wr_en   = 1'b1;
      cnt_wr_addr = rel_idx;
      cnt_wr_data = cnt_dec;
    end
  end

  khc_ram #(
    .WIDTH (KW2),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (scan),
    .wr_data (key_req),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (key_rd)
  );

  khc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (ENTRIES)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (cnt_rd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      cmp_live   <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key_req    <= {req.key_high, req.key_low};
            rel_slot   <= req.slot_in;
            scan       <= '0;
            cmp_live   <= 1'b0;
            issue_done <= 1'b0;
            unique case (op_t'(req.opcode))
              OP_LOOKUP: state <= S_LOOK;
              OP_INSERT: state <= S_INS;
              OP_RELEASE: begin
                if (in_range) begin
                  state <= S_REL_RD;
                end else begin
                  // slot beyond the table counts as empty
                  res   <= make_res(1'b0, req.slot_in, 1'b0, 1'b1, '0);
                  state <= S_EMIT;
                end
              end
              OP_CLEAR: begin
                valid <= '0;
                res   <= RES_NONE;
                state <= S_EMIT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LOOK: begin
          // issue side: one read per cycle until the last entry
          if (!issue_done) begin
            cmp_idx  <= scan;
            cmp_live <= 1'b1;
            if (scan == LAST) begin
              issue_done <= 1'b1;
            end else begin
              scan <= scan + IDX_ONE;
            end
          end else begin
            cmp_live <= 1'b0;
          end
          // compare side: lowest valid match wins
          if (look_hit) begin
            res   <= make_res(1'b1, cmp_slot_wide[SLOT_W-1:0], 1'b0, 1'b0,
                              inc_wide[COUNT_OUT_W-1:0]);
            state <= S_EMIT;
          end else if (cmp_live && (cmp_idx == LAST)) begin
            res   <= RES_NONE;
            state <= S_EMIT;
          end
        end
        S_INS: begin
          if (ins_free) begin
            valid[scan] <= 1'b1;
            res         <= make_res(1'b1, scan_slot_wide[SLOT_W-1:0], 1'b0, 1'b0,
                                    COUNT_OUT_W'(1));
            state       <= S_EMIT;
          end else if (scan == LAST) begin
            res   <= make_res(1'b0, '0, 1'b1, 1'b0, '0);
            state <= S_EMIT;
          end else begin
            scan <= scan + IDX_ONE;
          end
        end
        S_REL_RD: state <= S_REL;
        S_REL: begin
          if (rel_ok) begin
            res <= make_res(1'b0, rel_slot, 1'b0, 1'b0, dec_wide[COUNT_OUT_W-1:0]);
            if (cnt_dec == '0) begin
              valid[rel_idx] <= 1'b0;
            end
          end else begin
            res <= make_res(1'b0, rel_slot, 1'b0, 1'b1, '0);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register: holds one result beat until taken
  assign out_load = (state == S_EMIT) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_res.found;
  assign rsp.slot_out   = out_res.slot_out;
  assign rsp.table_full = out_res.table_full;
  assign rsp.underflow  = out_res.underflow;
  assign rsp.count_out  = out_res.count_out;

endmodule

`default_nettype wire
